### hdl/nstp_pkg.sv
// Package for the nested scope time profiler: sizes, status codes, actions, sequencer states, adder ops.
// No dependencies.
package nstp_pkg;

    localparam int TS_W = 63;
    localparam int CNT_W = 64;

    // Store sizes; the port widths of the top level are built around these.
    localparam int SCOPES = 16;
    localparam int FRAMES = 8;
    localparam int STACK_DEPTH = 16;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_DISABLED  = 4'd1,
        ST_ACTIVE    = 4'd2,
        ST_NOFRAME   = 4'd3,
        ST_NOHIST    = 4'd4,
        ST_BADSCOPE  = 4'd5,
        ST_NONMONO   = 4'd6,
        ST_FULL      = 4'd7,
        ST_EMPTY     = 4'd8,
        ST_MISMATCH  = 4'd9,
        ST_OVERFLOW  = 4'd10,
        ST_UNCLOSED  = 4'd11
    } status_t;

    typedef enum logic [2:0] {
        ACT_BEGIN = 3'd0,
        ACT_ENTER = 3'd1,
        ACT_EXIT  = 3'd2,
        ACT_END   = 3'd3,
        ACT_READ  = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_EX_RD,
        S_EX_DUR,
        S_EX_EXC,
        S_EX_INC,
        S_EX_XSUM,
        S_EX_CHILD,
        S_EX_WR,
        S_COPY_RD,
        S_COPY_WR,
        S_HIST_RD,
        S_HIST_OUT,
        S_DONE
    } state_t;

    // Shared 64-bit adder/subtractor operation.
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_INC
    } alu_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] sum;
        logic             carry;  // add: bit 63 overflow of 63-bit sum; sub: borrow
    } alu_res_t;

endpackage

### hdl/nstp_alu.sv
// Shared arithmetic unit of the profiler: one add, subtract or increment a cycle.
// Uses nstp_pkg.
module nstp_alu (
    input  nstp_pkg::alu_op_t  op,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output nstp_pkg::alu_res_t res
);
    import nstp_pkg::*;

    logic [64:0] wide;

    always_comb
    begin
        case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            ALU_INC: wide = {1'b0, a} + 65'd1;
            default: wide = '0;
        endcase
        res.sum = wide[63:0];
        case (op)
            ALU_ADD: res.carry = wide[63];   // operands are 63-bit
            ALU_SUB: res.carry = wide[64];
            ALU_INC: res.carry = wide[64];
            default: res.carry = 1'b0;
        endcase
    end

endmodule

### hdl/nested_scope_time_profiler_unit.sv
// Top level of the nested scope time profiler: sequencer, stack, timing stores, ring.
// Uses nstp_pkg and nstp_alu.
//
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | action scope_id timestamp frame_number history_offset
//  out     | output    | out_valid/stall | status hist_* scope_measured calls inclusive/exclusive_time
//  cfg     | input     | APB psel/penable| enabled (0x0), scope_count (0x4)
//
// Enter finishes in S_DECODE; exit steps S_EX_RD, DUR, EXC, INC, XSUM, CHILD and WR; read
// steps S_HIST_RD, S_HIST_OUT; begin walks the scopes in S_CLEAR, end in S_COPY_RD/S_COPY_WR,
// then S_DONE; all share the one adder. The next item is taken once out_valid drops.
// Reset clears control state only; no clearing pass, begin frame clears timings.
// in_stall is high while an item is at work or its result waits on out_stall.
module nested_scope_time_profiler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [3:0]  scope_id,
    input  logic [62:0] timestamp,
    input  logic [63:0] frame_number,
    input  logic [2:0]  history_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [63:0] hist_frame_number,
    output logic [62:0] hist_begin_time,
    output logic [62:0] hist_end_time,
    output logic [62:0] hist_duration,
    output logic        scope_measured,
    output logic [63:0] calls,
    output logic [62:0] inclusive_time,
    output logic [62:0] exclusive_time,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nstp_pkg::*;

    localparam int SW = (SCOPES > 1) ? $clog2(SCOPES) : 1;
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int DW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DCW = $clog2(STACK_DEPTH + 1);
    localparam int RCW = $clog2(FRAMES + 1);
    localparam int SCW = $clog2(SCOPES + 1);
    localparam int RW = FW + SW;
    localparam logic [4:0] SCOPES_CAP = (SCOPES > 31) ? 5'd31 : 5'(SCOPES);

    // ---------------- configuration ----------------
    logic       enabled_reg;
    logic [4:0] scope_count_reg;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            1'b0:    prdata = {31'd0, enabled_reg};
            default: prdata = {27'd0, scope_count_reg};
        endcase
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;
    logic              frame_open_reg, locked_reg;
    logic [62:0]       last_time_reg, ofn_begin_reg;
    logic [63:0]       ofn_num_reg;
    logic [DCW-1:0]    depth_reg;
    logic [FW-1:0]     ring_next_reg;
    logic [RCW-1:0]    ring_count_reg;

    // latched item
    logic [2:0]  act_reg;
    logic [3:0]  id_reg;
    logic [62:0] ts_reg;
    logic [63:0] fn_reg;
    logic [2:0]  off_reg;

    // work registers
    logic [SCW-1:0] idx_reg;
    logic [62:0] sbegin_reg, schild_reg, pchild_reg, dur_reg, exc_reg, ninc_reg, nexc_reg;
    logic [3:0]  sscope_reg;
    logic [63:0] cc_reg;
    logic [62:0] ci_reg, ce_reg;
    logic [FW-1:0] slot_reg;

    // output register
    logic        ov_reg;
    logic [3:0]  st_reg;
    logic [63:0] o_fn_reg, o_calls_reg;
    logic [62:0] o_b_reg, o_e_reg, o_d_reg, o_inc_reg, o_exc_reg;
    logic        o_m_reg;

    // ---------------- memories ----------------
    logic [3:0]  stk_scope_mem [STACK_DEPTH];
    logic [62:0] stk_begin_mem [STACK_DEPTH];
    logic [62:0] stk_child_mem [STACK_DEPTH];
    logic [189:0] cur_mem [SCOPES];         // {calls, incl, excl}
    logic         cur_m_mem [SCOPES];
    logic [190:0] rt_mem [FRAMES*SCOPES];    // {measured, calls, incl, excl}
    logic [252:0] rf_mem [FRAMES];           // {num, begin, end, duration}

    logic [190:0] cur_rd_reg, rt_rd_reg;
    logic [252:0] rf_rd_reg;
    logic [3:0]   stk_s_rd_reg;
    logic [62:0]  stk_b_rd_reg, stk_c_rd_reg, stk_p_rd_reg;

    // ---------------- shared adder ----------------
    alu_op_t  alu_op;
    logic [63:0] alu_a, alu_b;
    alu_res_t alu_res;
    nstp_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res));

    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a = {1'b0, ts_reg};
        alu_b = {1'b0, last_time_reg};
        case (state_reg)
            S_EX_DUR:   begin alu_a = {1'b0, ts_reg}; alu_b = {1'b0, sbegin_reg}; end
            S_EX_EXC:   begin alu_a = {1'b0, dur_reg}; alu_b = {1'b0, schild_reg}; end
            S_EX_INC:   begin alu_op = ALU_ADD; alu_a = {1'b0, ci_reg}; alu_b = {1'b0, dur_reg}; end
            S_EX_XSUM:  begin alu_op = ALU_ADD; alu_a = {1'b0, ce_reg}; alu_b = {1'b0, exc_reg}; end
            S_EX_CHILD: begin alu_op = ALU_ADD; alu_a = {1'b0, pchild_reg}; alu_b = {1'b0, dur_reg}; end
            S_EX_WR:    begin alu_op = ALU_INC; alu_a = cc_reg; alu_b = '0; end
            S_COPY_RD:  begin alu_a = {1'b0, ts_reg}; alu_b = {1'b0, ofn_begin_reg}; end
            default:    ;
        endcase
    end

    // ---------------- decode ----------------
    logic       in_acc, out_acc;
    logic       id_bad, ts_lt, read_bad_off, read_bad_id;
    logic [DW-1:0] top_idx, par_idx;
    logic [FW-1:0] hist_slot;
    logic [FW:0]   hist_tmp;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = ov_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign id_bad = {1'b0, id_reg} >= scope_count_reg;
    assign ts_lt = alu_res.carry;  // valid in S_DECODE (ts - last_time)
    assign read_bad_off = {{(8-RCW){1'b0}}, ring_count_reg} <= {5'd0, off_reg};
    assign read_bad_id = id_bad;
    assign top_idx = DW'(depth_reg - DCW'(1));
    assign par_idx = DW'(depth_reg - DCW'(2));
    always_comb
    begin
        hist_tmp = {1'b0, ring_next_reg} + (FW+1)'(FRAMES) - (FW+1)'(1)
                   - (FW+1)'({29'd0, off_reg} % FRAMES);
        hist_slot = FW'(hist_tmp % (FW+1)'(FRAMES));
    end
    logic last_idx;
    assign last_idx = (idx_reg + SCW'(1)) >= ((scope_count_reg > SCOPES_CAP) ?
                      SCW'(SCOPES_CAP) : SCW'(scope_count_reg));
    logic scopes_zero;
    assign scopes_zero = scope_count_reg == 5'd0;

    // next-state / status decision
    logic       fin;
    status_t    fin_st;
    logic       fin_abort;
    always_comb
    begin
        state_next = state_reg;
        fin = 1'b0;
        fin_st = ST_OK;
        fin_abort = 1'b0;
        case (state_reg)
            S_IDLE: if (in_acc) state_next = S_DECODE;
            S_DECODE:
            begin
                if (act_reg == ACT_READ)
                begin
                    if (read_bad_off) begin fin = 1'b1; fin_st = ST_NOHIST; end
                    else if (read_bad_id) begin fin = 1'b1; fin_st = ST_BADSCOPE; end
                    else state_next = S_HIST_RD;
                end
                else if (act_reg > ACT_READ) fin = 1'b1;
                else if (!enabled_reg) begin fin = 1'b1; fin_st = ST_DISABLED; end
                else if (act_reg == ACT_BEGIN)
                begin
                    if (frame_open_reg) begin fin = 1'b1; fin_st = ST_ACTIVE; end
                    else if (locked_reg && ts_lt) begin fin = 1'b1; fin_st = ST_NONMONO; end
                    else if (scopes_zero) fin = 1'b1;
                    else state_next = S_CLEAR;
                end
                else if (!frame_open_reg) begin fin = 1'b1; fin_st = ST_NOFRAME; end
                else if (act_reg == ACT_END)
                begin
                    fin = 1'b1;
                    if (ts_lt) begin fin_st = ST_NONMONO; fin_abort = 1'b1; end
                    else if (depth_reg != '0) begin fin_st = ST_UNCLOSED; fin_abort = 1'b1; end
                    else begin fin = 1'b0; state_next = S_COPY_RD; end
                end
                else if (id_bad) begin fin = 1'b1; fin_st = ST_BADSCOPE; fin_abort = 1'b1; end
                else if (ts_lt) begin fin = 1'b1; fin_st = ST_NONMONO; fin_abort = 1'b1; end
                else if (act_reg == ACT_ENTER)
                begin
                    fin = 1'b1;
                    if (depth_reg >= DCW'(STACK_DEPTH))
                    begin
                        fin_st = ST_FULL; fin_abort = 1'b1;
                    end
                end
                else if (depth_reg == '0) begin fin = 1'b1; fin_st = ST_EMPTY; fin_abort = 1'b1; end
                else state_next = S_EX_RD;
            end
            S_CLEAR: if (last_idx) fin = 1'b1;
            S_EX_RD: state_next = S_EX_DUR;
            S_EX_DUR:
                if (sscope_reg != id_reg) begin fin = 1'b1; fin_st = ST_MISMATCH; fin_abort = 1'b1; end
                else if (alu_res.carry) begin fin = 1'b1; fin_st = ST_NONMONO; fin_abort = 1'b1; end
                else state_next = S_EX_EXC;
            S_EX_EXC:
                if (alu_res.carry) begin fin = 1'b1; fin_st = ST_OVERFLOW; fin_abort = 1'b1; end
                else if (&cc_reg) begin fin = 1'b1; fin_st = ST_OVERFLOW; fin_abort = 1'b1; end
                else state_next = S_EX_INC;
            S_EX_INC:
                if (alu_res.carry) begin fin = 1'b1; fin_st = ST_OVERFLOW; fin_abort = 1'b1; end
                else state_next = S_EX_XSUM;
            S_EX_XSUM:
                if (alu_res.carry) begin fin = 1'b1; fin_st = ST_OVERFLOW; fin_abort = 1'b1; end
                else state_next = S_EX_CHILD;
            S_EX_CHILD:
                if (depth_reg > DCW'(1) && alu_res.carry)
                begin
                    fin = 1'b1; fin_st = ST_OVERFLOW; fin_abort = 1'b1;
                end
                else state_next = S_EX_WR;
            S_EX_WR: fin = 1'b1;
            S_COPY_RD: state_next = scopes_zero ? S_DONE : S_COPY_WR;
            S_COPY_WR: if (last_idx) state_next = S_DONE; else state_next = S_COPY_RD;
            S_HIST_RD: state_next = S_HIST_OUT;
            S_HIST_OUT: fin = 1'b1;
            S_DONE: fin = 1'b1;
            default: state_next = S_IDLE;
        endcase
        if (fin) state_next = S_IDLE;
    end

    // ---------------- memories ----------------
    logic [RW-1:0] rt_wa, rt_ra;
    assign rt_wa = {slot_reg, idx_reg[SW-1:0]};
    assign rt_ra = {hist_slot, id_reg[SW-1:0]};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECODE && act_reg == ACT_ENTER && fin && fin_st == ST_OK)
        begin
            stk_scope_mem[top_idx + DW'(1)] <= id_reg;
            stk_begin_mem[top_idx + DW'(1)] <= ts_reg;
            stk_child_mem[top_idx + DW'(1)] <= '0;
        end
        if (state_reg == S_EX_WR && depth_reg > DCW'(1))
            stk_child_mem[par_idx] <= pchild_reg;
        stk_s_rd_reg <= stk_scope_mem[top_idx];
        stk_b_rd_reg <= stk_begin_mem[top_idx];
        stk_c_rd_reg <= stk_child_mem[top_idx];
        stk_p_rd_reg <= stk_child_mem[par_idx];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            cur_mem[idx_reg[SW-1:0]] <= '0;
            cur_m_mem[idx_reg[SW-1:0]] <= 1'b0;
        end
        else if (state_reg == S_EX_WR)
        begin
            cur_mem[id_reg[SW-1:0]] <= {alu_res.sum, ninc_reg, nexc_reg};
            cur_m_mem[id_reg[SW-1:0]] <= 1'b1;
        end
        cur_rd_reg <= {cur_m_mem[(state_reg == S_EX_RD) ? id_reg[SW-1:0] : idx_reg[SW-1:0]],
                       cur_mem[(state_reg == S_EX_RD) ? id_reg[SW-1:0] : idx_reg[SW-1:0]]};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_COPY_WR)
            rt_mem[rt_wa] <= cur_rd_reg;
        rt_rd_reg <= rt_mem[rt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_COPY_RD && idx_reg == '0)
            rf_mem[slot_reg] <= {ofn_num_reg, ofn_begin_reg, ts_reg, alu_res.sum[62:0]};
        rf_rd_reg <= rf_mem[hist_slot];
    end

    // ---------------- sequencer registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            enabled_reg <= 1'b1;
            scope_count_reg <= '0;
            frame_open_reg <= 1'b0;
            locked_reg <= 1'b0;
            last_time_reg <= '0;
            ofn_num_reg <= '0;
            ofn_begin_reg <= '0;
            depth_reg <= '0;
            ring_next_reg <= '0;
            ring_count_reg <= '0;
            ov_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && paddr[2] == 1'b0)
            begin
                if (!pwdata[0] && enabled_reg && frame_open_reg)
                begin
                    frame_open_reg <= 1'b0;
                    depth_reg <= '0;
                end
                enabled_reg <= pwdata[0];
            end
            else if (cfg_wr && paddr[2] == 1'b1 && !locked_reg)
                scope_count_reg <= (pwdata[4:0] > SCOPES_CAP) ? SCOPES_CAP : pwdata[4:0];

            if (out_acc) ov_reg <= 1'b0;
            if (fin) ov_reg <= 1'b1;
            if (fin && fin_abort)
            begin
                frame_open_reg <= 1'b0;
                depth_reg <= '0;
            end
            if (state_reg == S_IDLE) idx_reg <= '0;

            case (state_reg)
                S_DECODE:
                    if (fin && fin_st == ST_OK && act_reg == ACT_BEGIN || state_next == S_CLEAR)
                    begin
                        locked_reg <= 1'b1;
                        ofn_num_reg <= fn_reg;
                        ofn_begin_reg <= ts_reg;
                        last_time_reg <= ts_reg;
                        depth_reg <= '0;
                        frame_open_reg <= 1'b1;
                    end
                    else if (fin && fin_st == ST_OK && act_reg == ACT_ENTER)
                    begin
                        depth_reg <= depth_reg + DCW'(1);
                        last_time_reg <= ts_reg;
                    end
                S_CLEAR: idx_reg <= idx_reg + SCW'(1);
                S_EX_WR:
                begin
                    depth_reg <= depth_reg - DCW'(1);
                    last_time_reg <= ts_reg;
                end
                S_COPY_WR: idx_reg <= idx_reg + SCW'(1);
                S_DONE:
                begin
                    if (act_reg == ACT_END)
                    begin
                        if ({{(8-RCW){1'b0}}, ring_count_reg} < 8'(FRAMES))
                            ring_count_reg <= ring_count_reg + RCW'(1);
                        ring_next_reg <= (slot_reg == FW'(FRAMES - 1)) ? '0 : slot_reg + FW'(1);
                        frame_open_reg <= 1'b0;
                        last_time_reg <= ts_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg <= action;
            id_reg <= scope_id;
            ts_reg <= timestamp;
            fn_reg <= frame_number;
            off_reg <= history_offset;
            slot_reg <= ring_next_reg;
        end
        case (state_reg)
            S_EX_RD: ;
            S_EX_DUR:
            begin
                dur_reg <= alu_res.sum[62:0];
            end
            S_EX_EXC: exc_reg <= alu_res.sum[62:0];
            S_EX_INC: ninc_reg <= alu_res.sum[62:0];
            S_EX_XSUM: nexc_reg <= alu_res.sum[62:0];
            S_EX_CHILD: pchild_reg <= alu_res.sum[62:0];
            default: ;
        endcase
        if (state_reg == S_EX_RD || state_reg == S_DECODE)
        begin
            sscope_reg <= stk_s_rd_reg;
            sbegin_reg <= stk_b_rd_reg;
            schild_reg <= stk_c_rd_reg;
            if (state_reg == S_EX_RD) pchild_reg <= stk_p_rd_reg;
        end
        if (state_reg == S_EX_DUR)
        begin
            cc_reg <= cur_rd_reg[189:126];
            ci_reg <= cur_rd_reg[125:63];
            ce_reg <= cur_rd_reg[62:0];
        end
        if (fin)
        begin
            st_reg <= fin_st;
            if (state_reg == S_HIST_OUT)
            begin
                {o_fn_reg, o_b_reg, o_e_reg, o_d_reg} <= rf_rd_reg;
                o_m_reg <= rt_rd_reg[190];
                o_calls_reg <= rt_rd_reg[189:126];
                o_inc_reg <= rt_rd_reg[125:63];
                o_exc_reg <= rt_rd_reg[62:0];
            end
            else
            begin
                o_fn_reg <= '0; o_b_reg <= '0; o_e_reg <= '0; o_d_reg <= '0;
                o_m_reg <= 1'b0; o_calls_reg <= '0; o_inc_reg <= '0; o_exc_reg <= '0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign hist_frame_number = o_fn_reg;
    assign hist_begin_time = o_b_reg;
    assign hist_end_time = o_e_reg;
    assign hist_duration = o_d_reg;
    assign scope_measured = o_m_reg;
    assign calls = o_calls_reg;
    assign inclusive_time = o_inc_reg;
    assign exclusive_time = o_exc_reg;

    // ---------------- assertions ----------------
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DCW'(STACK_DEPTH))
        else $error("stack depth beyond limit");
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> depth_reg == '0)
        else $error("stack not empty without an open frame");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_ring_count: assert property (@(posedge clk) disable iff (!rst_n)
        {{(8-RCW){1'b0}}, ring_count_reg} <= 8'(FRAMES))
        else $error("ring count beyond depth");

endmodule
